// ===== rtl/core/crf_pkg.sv =====
// crf_pkg: shared types, codes and constants of the clipped rectangle fill engine.
// Standalone package, no dependencies; imported by clipped_rectangle_fill_top.
package crf_pkg;

  // Default frame store geometry.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Frame size register width and its reset value.
  localparam int        DIM_W         = 7;
  localparam logic [6:0] FRAME_DIM_RST = 7'd64;

  // Operation codes of an input item.
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam pixel_t BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

  // Clip-limit coordinate: holds raw corners +/- 1 and frame limits.
  typedef logic signed [9:0] coord_t;

  // Effective frame dimension: 0 counts as 1, saturates at the store size.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim, input int maxv);
    logic [DIM_W-1:0] d;
    d = dim;
    if (d == '0) d = DIM_W'(1);
    if (32'(d) > maxv) d = DIM_W'(maxv);
    return d;
  endfunction

endpackage

// ===== rtl/core/clipped_rectangle_fill_top.sv =====
// clipped_rectangle_fill_top: rectangle fill engine with an on-chip RGB frame store.
// Read item: the store is read in S_READ, then the result is registered in S_DONE. Draw item:
//   S_SETUP, then one store write per cycle in S_FILL, with an outline pass first with a border.
// One item at a time: in_ready is high only while the sequencer idles.
// Reset (rst_n, synchronous, active low) clears control and frame size registers;
//   the frame store is not cleared and holds undefined data until drawn. Uses crf_pkg.
module clipped_rectangle_fill_top #(
  parameter int MAX_WIDTH  = crf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = crf_pkg::MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  // input item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic signed [7:0] in_corner_ax,
  input  logic signed [7:0] in_corner_ay,
  input  logic signed [7:0] in_corner_bx,
  input  logic signed [7:0] in_corner_by,
  input  logic [7:0] in_fill_red,
  input  logic [7:0] in_fill_green,
  input  logic [7:0] in_fill_blue,
  input  logic       in_with_border,
  input  logic [5:0] in_read_x,
  input  logic [5:0] in_read_y,
  // result item channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_pixel_data,
  output logic [7:0] out_pixel_red,
  output logic [7:0] out_pixel_green,
  output logic [7:0] out_pixel_blue
);
  import crf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 8;                    // product width for row base
  localparam logic [PW-1:0] WSTEP = PW'(MAX_WIDTH); // one row of the store

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item
    S_READ,   // store read in flight
    S_SETUP,  // order and clip one rectangle pass
    S_FILL,   // one pixel written per cycle
    S_DONE    // hand result to the output register
  } state_t;

  // ---------------------------------------------------------------------------
  // Frame size registers. Writes must only arrive while idle; the block itself does not enforce it.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [DIM_W-1:0] w_eff, h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_DIM_RST;
      frame_height_r <= FRAME_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
      endcase
    end
  end

  assign w_eff = eff_dim(frame_width_r, MAX_WIDTH);
  assign h_eff = eff_dim(frame_height_r, MAX_HEIGHT);

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  state_t           state_r;
  logic             op_r;
  logic             border_r;      // current pass is the black outline
  logic signed [7:0] ax_r, ay_r, bx_r, by_r;
  pixel_t           colour_r;
  logic [DIM_W-1:0] lft_r, rgt_r, bot_r, x_r, y_r;
  logic [AW-1:0]    row_r;         // store address of (left, y)
  logic [AW-1:0]    addr_r;        // store address of (x, y)
  logic [AW-1:0]    rd_addr_r;
  logic             rd_ok_r;       // read lies inside the frame
  pixel_t           rd_data_r;

  logic             out_valid_r;
  logic             out_pix_r;
  pixel_t           out_data_r;

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_pixel_data = out_pix_r;
  assign out_pixel_red     = out_data_r.red;
  assign out_pixel_green   = out_data_r.green;
  assign out_pixel_blue    = out_data_r.blue;

  // ---------------------------------------------------------------------------
  // Setup: order the corners of this pass and clip to the frame. The border pass
  // uses the raw corners stretched by one; an inverted pair shrinks instead.
  // ---------------------------------------------------------------------------
  coord_t x1, y1, x2, y2, lo_x, hi_x, lo_y, hi_y, x_lim, y_lim;
  logic   rect_empty;
  logic [PW-1:0] row_base;

  always_comb begin
    x1 = $signed({{2{ax_r[7]}}, ax_r});
    y1 = $signed({{2{ay_r[7]}}, ay_r});
    x2 = $signed({{2{bx_r[7]}}, bx_r});
    y2 = $signed({{2{by_r[7]}}, by_r});
    if (border_r) begin
      x1 = x1 - 10'sd1;
      y1 = y1 - 10'sd1;
      x2 = x2 + 10'sd1;
      y2 = y2 + 10'sd1;
    end
    lo_x  = (x1 < x2) ? x1 : x2;
    hi_x  = (x1 < x2) ? x2 : x1;
    lo_y  = (y1 < y2) ? y1 : y2;
    hi_y  = (y1 < y2) ? y2 : y1;
    x_lim = $signed({3'b000, w_eff}) - 10'sd1;
    y_lim = $signed({3'b000, h_eff}) - 10'sd1;
    if (lo_x < 10'sd0) lo_x = 10'sd0;
    if (lo_y < 10'sd0) lo_y = 10'sd0;
    if (hi_x > x_lim)  hi_x = x_lim;
    if (hi_y > y_lim)  hi_y = y_lim;
    rect_empty = (lo_x > hi_x) || (lo_y > hi_y);
    // top row base; lo_y is within 0..126 here when the pass is not empty
    row_base   = PW'(lo_y[6:0]) * WSTEP;
  end

  // read address of a read item, straight from the input ports
  logic [PW-1:0] rd_addr_full;
  logic          rd_in_frame;

  assign rd_addr_full = PW'(in_read_y) * WSTEP + PW'(in_read_x);
  assign rd_in_frame  = ({1'b0, in_read_x} < w_eff) && ({1'b0, in_read_y} < h_eff);

  // stepping unit of the fill loop
  logic             row_end, last_px;
  logic [AW-1:0]    row_next;

  assign row_end  = (x_r == rgt_r);
  assign last_px  = row_end && (y_r == bot_r);
  assign row_next = row_r + WSTEP[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      border_r    <= 1'b0;
      op_r        <= OP_DRAW;
    end else begin
      // the hand-over state drives out_valid_r itself
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_operation;
            ax_r      <= in_corner_ax;
            ay_r      <= in_corner_ay;
            bx_r      <= in_corner_bx;
            by_r      <= in_corner_by;
            colour_r  <= '{red: in_fill_red, green: in_fill_green, blue: in_fill_blue};
            border_r  <= in_with_border;
            rd_addr_r <= rd_addr_full[AW-1:0];
            rd_ok_r   <= rd_in_frame;
            state_r   <= (in_operation == OP_READ) ? S_READ : S_SETUP;
          end
        end

        S_READ: state_r <= S_DONE;

        S_SETUP: begin
          lft_r  <= lo_x[DIM_W-1:0];
          rgt_r  <= hi_x[DIM_W-1:0];
          bot_r  <= hi_y[DIM_W-1:0];
          x_r    <= lo_x[DIM_W-1:0];
          y_r    <= lo_y[DIM_W-1:0];
          row_r  <= row_base[AW-1:0];
          addr_r <= row_base[AW-1:0] + AW'(lo_x[DIM_W-1:0]);
          if (!rect_empty) begin
            state_r <= S_FILL;
          end else if (border_r) begin
            border_r <= 1'b0;            // nothing of the outline is visible
          end else begin
            state_r <= S_DONE;
          end
        end

        S_FILL: begin
          if (last_px) begin
            if (border_r) begin
              border_r <= 1'b0;
              state_r  <= S_SETUP;
            end else begin
              state_r  <= S_DONE;
            end
          end else if (row_end) begin
            x_r    <= lft_r;
            y_r    <= y_r + DIM_W'(1);
            row_r  <= row_next;
            addr_r <= row_next + AW'(lft_r);
          end else begin
            x_r    <= x_r + DIM_W'(1);
            addr_r <= addr_r + AW'(1);
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pix_r   <= (op_r == OP_READ);
            out_data_r  <= (op_r == OP_READ && rd_ok_r) ? rd_data_r : BLACK;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame store: one write port for the fill loop, one registered read port.
  // ---------------------------------------------------------------------------
  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (state_r == S_FILL) mem[addr_r] <= border_r ? BLACK : colour_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) rd_data_r <= mem[rd_addr_r];
  end

`ifndef NO_ASSERTIONS
  // a result only appears from the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside hand-over");

  // the fill walker never leaves its clipped span
  a_fill_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (x_r >= lft_r && x_r <= rgt_r && y_r <= bot_r
                              && x_r < w_eff && y_r < h_eff))
    else $error("fill walker outside rectangle");

  // every write lands inside the store
  a_fill_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (32'(addr_r) < DEPTH))
    else $error("store write out of range");

  // an accepted item closes the input until it is finished
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");
`endif

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for clipped_rectangle_fill_top, with a pixel-accurate frame
// store model, valid/ready drivers on all three channels and random stalls on both sides.
// Depends on crf_pkg and clipped_rectangle_fill_top only.
`timescale 1ns / 1ps

module tb_top;
  import crf_pkg::*;

  localparam int STORE_W         = MAX_WIDTH_DEF;
  localparam int STORE_H         = MAX_HEIGHT_DEF;
  // Results leave as soon as the sequencer finishes, so a short settle is enough.
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 20;

  // One input item as the bench sees it.
  typedef struct {
    logic              op;
    logic signed [7:0] ax, ay, bx, by;
    pixel_t            colour;
    logic              border;
    logic [5:0]        rx, ry;
  } fill_cmd_t;

  // One result item: acknowledge or pixel read.
  typedef struct {
    logic   is_pixel;
    pixel_t px;
  } reply_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [6:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic              in_operation;
  logic signed [7:0] in_corner_ax;
  logic signed [7:0] in_corner_ay;
  logic signed [7:0] in_corner_bx;
  logic signed [7:0] in_corner_by;
  logic [7:0]        in_fill_red;
  logic [7:0]        in_fill_green;
  logic [7:0]        in_fill_blue;
  logic              in_with_border;
  logic [5:0]        in_read_x;
  logic [5:0]        in_read_y;
  logic              out_valid;
  logic              out_ready;
  logic              out_is_pixel_data;
  logic [7:0]        out_pixel_red;
  logic [7:0]        out_pixel_green;
  logic [7:0]        out_pixel_blue;

  // Shadow of the frame store and of the two size registers.
  pixel_t     frame_model [STORE_W*STORE_H];
  logic [6:0] width_reg  = FRAME_DIM_RST;
  logic [6:0] height_reg = FRAME_DIM_RST;

  // Replies still owed by the block, oldest first.
  reply_t reply_queue [$];

  int mismatch_count  = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_off_cycles = 0;

  // Corners of the latest random draw, so that reads can probe its edges.
  int last_ax = 0, last_ay = 0, last_bx = 0, last_by = 0;

  clipped_rectangle_fill_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, even with every draw at full frame.
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Size register to visible size: zero acts as one, large values saturate.
  function automatic int clip_limit(input logic [6:0] size_reg, input int maxv);
    int d;
    d = size_reg;
    if (d < 1) d = 1;
    if (d > maxv) d = maxv;
    return d;
  endfunction

  // Orders the corners, clips to the visible frame and paints inclusively.
  task automatic paint_box(input int w, input int h, input int x1, input int y1,
                           input int x2, input int y2, input pixel_t colour);
    int lft, rgt, top, bot;
    lft = (x1 < x2) ? x1 : x2;
    rgt = (x1 < x2) ? x2 : x1;
    top = (y1 < y2) ? y1 : y2;
    bot = (y1 < y2) ? y2 : y1;
    if (lft < 0) lft = 0;
    if (rgt >= w) rgt = w - 1;
    if (top < 0) top = 0;
    if (bot >= h) bot = h - 1;
    for (int y = top; y <= bot; y++) begin
      for (int x = lft; x <= rgt; x++) begin
        frame_model[y*STORE_W + x] = colour;
      end
    end
  endtask

  // Applies one accepted item to the model and queues the reply it owes.
  task automatic compute_reply(input fill_cmd_t c);
    int     w, h, rx, ry;
    reply_t r;
    w = clip_limit(width_reg, STORE_W);
    h = clip_limit(height_reg, STORE_H);
    if (c.op == OP_DRAW) begin
      // Outline comes from the raw corners pushed out by one; reversed corners shrink it.
      if (c.border)
        paint_box(w, h, int'(c.ax) - 1, int'(c.ay) - 1, int'(c.bx) + 1, int'(c.by) + 1,
                  BLACK);
      paint_box(w, h, c.ax, c.ay, c.bx, c.by, c.colour);
      r.is_pixel = 1'b0;
      r.px       = BLACK;
    end else begin
      rx         = c.rx;
      ry         = c.ry;
      r.is_pixel = 1'b1;
      r.px       = (rx < w && ry < h) ? frame_model[ry*STORE_W + rx] : BLACK;
    end
    reply_queue.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Item builders (unused fields always carry junk)
  // ---------------------------------------------------------------------------

  function automatic pixel_t random_colour();
    pixel_t p;
    p = 24'($urandom);
    return p;
  endfunction

  function automatic fill_cmd_t make_draw(input int ax, input int ay, input int bx,
                                          input int by, input pixel_t colour,
                                          input logic border);
    fill_cmd_t c;
    c.op     = OP_DRAW;
    c.ax     = 8'(ax);
    c.ay     = 8'(ay);
    c.bx     = 8'(bx);
    c.by     = 8'(by);
    c.colour = colour;
    c.border = border;
    c.rx     = 6'($urandom);
    c.ry     = 6'($urandom);
    return c;
  endfunction

  function automatic fill_cmd_t make_read(input int rx, input int ry);
    fill_cmd_t c;
    c.op     = OP_READ;
    c.ax     = 8'($urandom);
    c.ay     = 8'($urandom);
    c.bx     = 8'($urandom);
    c.by     = 8'($urandom);
    c.colour = random_colour();
    c.border = 1'($urandom);
    c.rx     = 6'(rx);
    c.ry     = 6'(ry);
    return c;
  endfunction

  // Mostly small boxes anywhere in or just past the frame; one draw in ten uses the full corner range.
  // Reads mostly probe one pixel around a corner of the latest draw.
  function automatic fill_cmd_t random_cmd();
    int x0, y0, dx, dy, bx, by, rx, ry;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        last_ax = int'($urandom_range(0, 255)) - 128;
        last_ay = int'($urandom_range(0, 255)) - 128;
        last_bx = int'($urandom_range(0, 255)) - 128;
        last_by = int'($urandom_range(0, 255)) - 128;
      end else begin
        x0 = int'($urandom_range(0, 71)) - 4;
        y0 = int'($urandom_range(0, 71)) - 4;
        dx = $urandom_range(0, 7);
        dy = $urandom_range(0, 7);
        last_ax = x0;
        last_bx = x0 + dx;
        last_ay = y0;
        last_by = y0 + dy;
        if ($urandom_range(0, 1)) begin
          last_ax = x0 + dx;
          last_bx = x0;
        end
        if ($urandom_range(0, 1)) begin
          last_ay = y0 + dy;
          last_by = y0;
        end
      end
      return make_draw(last_ax, last_ay, last_bx, last_by, random_colour(),
                       1'($urandom));
    end
    if ($urandom_range(0, 2) != 0) begin
      bx = $urandom_range(0, 1) ? last_ax : last_bx;
      by = $urandom_range(0, 1) ? last_ay : last_by;
      rx = (bx + int'($urandom_range(0, 2)) - 1) & 63;
      ry = (by + int'($urandom_range(0, 2)) - 1) & 63;
      return make_read(rx, ry);
    end
    return make_read($urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one item from a falling edge, with random idle cycles first, and books
  // its reply at the accepting edge. Valid stays up until the next item or a drain.
  task automatic send_item(input fill_cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation   = c.op;
    in_corner_ax   = c.ax;
    in_corner_ay   = c.ay;
    in_corner_bx   = c.bx;
    in_corner_by   = c.by;
    in_fill_red    = c.colour.red;
    in_fill_green  = c.colour.green;
    in_fill_blue   = c.colour.blue;
    in_with_border = c.border;
    in_read_x      = c.rx;
    in_read_y      = c.ry;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    compute_reply(c);
  endtask

  // Register write; only ever called with the block drained.
  task automatic write_frame_reg(input logic idx, input logic [6:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drops valid, waits for every owed reply, then lets the block settle.
  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_frame(input logic [6:0] w, input logic [6:0] h);
    wait_idle(SETTLE_CYCLES);
    write_frame_reg(CFG_FRAME_WIDTH, w);
    write_frame_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_queue.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got is_pixel_data=%0b",
                 $time, out_is_pixel_data);
        mismatch_count++;
      end else begin
        want = reply_queue.pop_front();
        report_field("is_pixel_data", 8'(want.is_pixel), 8'(out_is_pixel_data));
        report_field("pixel_red", want.px.red, out_pixel_red);
        report_field("pixel_green", want.px.green, out_pixel_green);
        report_field("pixel_blue", want.px.blue, out_pixel_blue);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Whole-range corners cover every store entry, so no later read hits an unwritten pixel.
  task automatic test_full_frame();
    send_item(make_draw(-128, -128, 127, 127, '{8'hFF, 8'h00, 8'hAA}, 1'b1));
    send_item(make_read(0, 0));
    send_item(make_read(63, 63));
  endtask

  // Reversed corners: outline shrinks inside the fill. Then a normal outlined box.
  task automatic test_corner_order();
    send_item(make_draw(20, 20, 10, 10, '{8'h12, 8'h34, 8'h56}, 1'b1));
    send_item(make_read(10, 10));
    send_item(make_read(20, 20));
    send_item(make_read(9, 15));
    send_item(make_draw(30, 5, 40, 12, '{8'h00, 8'hFF, 8'h55}, 1'b1));
    send_item(make_read(29, 4));
    send_item(make_read(41, 13));
  endtask

  // Box wholly off the frame writes nothing; its outline may still clip onto the edge.
  task automatic test_off_frame();
    send_item(make_draw(-50, -50, -1, -1, '{8'h77, 8'h77, 8'h77}, 1'b0));
    send_item(make_read(0, 0));
    send_item(make_draw(64, 0, 127, 10, '{8'h99, 8'h88, 8'h01}, 1'b1));
    send_item(make_read(63, 5));
    send_item(make_draw(5, 5, 5, 5, '{8'hC3, 8'h3C, 8'hFF}, 1'b0));
    send_item(make_read(5, 5));
  endtask

  // Zero size acts as one, oversize saturates; reads past the frame come back black.
  task automatic test_frame_size();
    set_frame(7'd0, 7'd127);
    send_item(make_draw(-128, -128, 127, 127, '{8'h5A, 8'hA5, 8'h0F}, 1'b0));
    send_item(make_read(0, 40));
    send_item(make_read(1, 40));
    set_frame(7'd127, 7'd0);
    send_item(make_read(63, 0));
    send_item(make_read(0, 1));
    set_frame(7'd1, 7'd1);
    send_item(make_read(0, 0));
    set_frame(7'd64, 7'd64);
  endtask

  // Four idling and stalling phases; each phase after the first sets its own frame size.
  task automatic test_random_traffic();
    int idle_tab  [4] = '{0, 54, 0, 37};
    int stall_tab [4] = '{0, 0, 54, 37};
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        set_frame(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(16, 64)),
                  ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(16, 64)));
      end
      send_idle_pct = idle_tab[phase];
      stall_pct     = stall_tab[phase];
      repeat (ITEMS_PER_PHASE) send_item(random_cmd());
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_output_backpressure();
    wait_idle(SETTLE_CYCLES);
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = 300;
    repeat (6) send_item(make_read($urandom_range(0, 63), $urandom_range(0, 63)));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FRAME_WIDTH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_operation   = OP_DRAW;
    in_corner_ax   = '0;
    in_corner_ay   = '0;
    in_corner_bx   = '0;
    in_corner_by   = '0;
    in_fill_red    = '0;
    in_fill_green  = '0;
    in_fill_blue   = '0;
    in_with_border = 1'b0;
    in_read_x      = '0;
    in_read_y      = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_full_frame();
    test_corner_order();
    test_off_frame();
    test_frame_size();
    test_random_traffic();
    test_output_backpressure();
    wait_idle(2 * SETTLE_CYCLES);

    if (mismatch_count == 0 && reply_queue.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/crf_pkg.sv
rtl/core/clipped_rectangle_fill_top.sv
sim/tb_top.sv
